FILE: src/bfloat16_to_int8_convert_defines.svh
// Assertion macros shared by the conversion block.
`ifndef BFLOAT16_TO_INT8_CONVERT_DEFINES_SVH
`define BFLOAT16_TO_INT8_CONVERT_DEFINES_SVH
`define BF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: src/bf2i8_pkg.sv
// Package with rounding mode codes and field widths for the conversion block.
package bf2i8_pkg;
	localparam int unsigned BfWidth = 16;
	localparam int unsigned ModeWidth = 3;
	localparam logic [7:0] ExpMax = 8'hFF;
	localparam logic [7:0] ExpIntPoint = 8'd134;
	localparam logic [7:0] PosSat = 8'h7F;
	localparam logic [7:0] NegSat = 8'h80;
	typedef enum logic [ModeWidth-1:0] {
		RM_NEAREST_EVEN = 3'd0,
		RM_TOWARD_ZERO  = 3'd1,
		RM_DOWN         = 3'd2,
		RM_UP           = 3'd3,
		RM_NEAREST_MAX  = 3'd4
	} round_mode_t;
endpackage

FILE: src/bf2i8_if.sv
// Valid/ready channel interfaces for input and result items.
interface bf2i8_in_if;
	logic valid;
	logic ready;
	logic [15:0] bf16_value;
	logic [2:0] rounding_mode;
	modport source(output valid, bf16_value, rounding_mode, input ready);
	modport sink(input valid, bf16_value, rounding_mode, output ready);
endinterface

interface bf2i8_out_if;
	logic valid;
	logic ready;
	logic signed [7:0] int_value;
	logic invalid_flag;
	logic inexact_flag;
	modport source(output valid, int_value, invalid_flag, inexact_flag, input ready);
	modport sink(input valid, int_value, invalid_flag, inexact_flag, output ready);
endinterface

FILE: src/bfloat16_to_int8_convert.sv
// Top level: bfloat16 to signed 8-bit integer conversion with rounding modes.
//
// Channel  Role    Payload
// in       sink    bf16_value, rounding_mode
// out      source  int_value, invalid_flag, inexact_flag
//
// Each item is registered at input, converted in one combinational pass and
// held in the result register: one item per cycle while out.ready stays high.
// The input register refills whenever the result register is empty or is
// being taken, so a stalled result blocks at most one more item.
// Reset clears both valid bits; payload registers are not reset.
`include "bfloat16_to_int8_convert_defines.svh"
module bfloat16_to_int8_convert (
	input logic clk,
	input logic arst_n,
	bf2i8_in_if.sink in,
	bf2i8_out_if.source out
);
	import bf2i8_pkg::*;

	logic v_s1, v_s2;
	logic [15:0] bits_s1;
	logic [2:0] mode_s1;
	logic [7:0] res_s2;
	logic inv_s2, inx_s2;
	logic adv;

	logic neg, nan, inf_exp, over_exp, sub;
	logic [7:0] ex, sig, ipart, rs, res_c;
	logic [6:0] frac;
	logic [8:0] mag;
	logic [15:0] wide;
	logic half, sticky, inc, inv_c, inx_c, over;

	assign adv = !v_s2 || out.ready;
	assign in.ready = !v_s1 || adv;

	always_comb begin
		neg = bits_s1[15];
		ex = bits_s1[14:7];
		frac = bits_s1[6:0];
		sig = {(ex != 8'd0), frac};
		inf_exp = (ex == ExpMax);
		nan = inf_exp && (frac != 7'd0);
		over_exp = !inf_exp && (ex > ExpIntPoint);
		sub = (ex == 8'd0);
		rs = sub ? 8'd16 : (ExpIntPoint - ex);
		if (rs > 8'd16) rs = 8'd16;
		wide = {sig, 8'd0} >> rs[4:0];
		ipart = wide[15:8];
		half = wide[7];
		sticky = (wide[6:0] != 7'd0) || (rs[4] && sig != 8'd0);
		if (sub) begin
			half = 1'b0;
			ipart = 8'd0;
		end
		inx_c = half || sticky;
		case (mode_s1)
			RM_NEAREST_EVEN: inc = half && (sticky || ipart[0]);
			RM_DOWN: inc = neg && inx_c;
			RM_UP: inc = !neg && inx_c;
			RM_NEAREST_MAX: inc = half;
			default: inc = 1'b0;
		endcase
		mag = {1'b0, ipart} + {8'd0, inc};
		over = over_exp || (neg ? (mag > 9'd128) : (mag > 9'd127));
		inv_c = inf_exp || over;
		if (nan) neg = 1'b0;
		if (inv_c) begin
			inx_c = 1'b0;
			res_c = neg ? NegSat : PosSat;
		end else begin
			res_c = neg ? (8'd0 - mag[7:0]) : mag[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in.ready) v_s1 <= in.valid;
			if (adv) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			bits_s1 <= in.bf16_value;
			mode_s1 <= in.rounding_mode;
		end
		if (adv && v_s1) begin
			res_s2 <= res_c;
			inv_s2 <= inv_c;
			inx_s2 <= inx_c;
		end
	end

	assign out.valid = v_s2;
	assign out.int_value = res_s2;
	assign out.invalid_flag = inv_s2;
	assign out.inexact_flag = inx_s2;

	`BF_ASSERT_IMPL(a_flags_excl, clk, arst_n, v_s2, !(inv_s2 && inx_s2),
		"invalid and inexact both set")
	`BF_ASSERT_NEXT(a_hold, clk, arst_n, v_s2 && !out.ready, v_s2 && $stable(res_s2),
		"stalled result changed")
	`BF_ASSERT_IMPL(a_sat, clk, arst_n, v_s2 && inv_s2,
		res_s2 == PosSat || res_s2 == NegSat, "invalid result not saturated")
	`BF_ASSERT_NEXT(a_move, clk, arst_n, v_s1 && adv, v_s2,
		"stage one item lost")
endmodule
